[src/lru_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_pkg: shared types and constants of the LRU recency tracker
// Command codes, item and result structs, default sizes.
// ----------------------------------------------------------------------------
package lru_pkg;

  // default sizes
  localparam int unsigned ENTRIES_DEF  = 32;
  localparam int unsigned KEY_BITS_DEF = 16;

  // field widths fixed by the item formats
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned COUNT_W = 6;

  // command codes
  localparam logic [CMD_W-1:0] CMD_USE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
  } item_t;

  typedef struct packed {
    logic [KEY_W-1:0]   oldest_key;
    logic               oldest_valid;
    logic               was_present;
    logic [COUNT_W-1:0] fill_count;
    logic               overflow;
  } result_t;

endpackage
`default_nettype wire

[src/lru_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_core: recency list storage and update
// Holds the key row oldest first, matches all entries in parallel, closes
// the gap left by a moved or removed key and forms the result of each item.
// ----------------------------------------------------------------------------
module lru_core #(
  parameter int unsigned ENTRIES  = lru_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS = lru_pkg::KEY_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire lru_pkg::item_t  item,
  output lru_pkg::result_t     result
);

  localparam int unsigned KW = (KEY_BITS < lru_pkg::KEY_W) ? KEY_BITS : lru_pkg::KEY_W;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  logic [KW-1:0] keys      [ENTRIES];
  logic [KW-1:0] keys_next [ENTRIES];
  logic [CW-1:0] held;
  logic [CW-1:0] held_next;

  logic [KW-1:0]      key_m;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] at_or_after;
  logic               present;
  logic               full;
  logic               do_shift;
  logic               do_write;
  logic               refused;
  logic [CW-1:0]      wpos;

  assign key_m = item.key[KW-1:0];
  assign full  = (held == CW'(ENTRIES));

  // match every held entry against the key
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = (CW'(i) < held) && (keys[i] == key_m);
    end
  end

  assign present = |match;

  // mark entries at or beyond the match position
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      at_or_after[i] = |(match & ((ENTRIES)'({ENTRIES{1'b1}}) >> (ENTRIES - 1 - i)));
    end
  end

  // decide the list change for this item
  always_comb begin
    do_shift  = 1'b0;
    do_write  = 1'b0;
    refused   = 1'b0;
    wpos      = held;
    held_next = held;
    case (item.cmd)
      lru_pkg::CMD_USE: begin
        if (present) begin
          do_shift = 1'b1;
          do_write = 1'b1;
          wpos     = held - CW'(1);
        end else if (full) begin
          refused = 1'b1;
        end else begin
          do_write  = 1'b1;
          held_next = held + CW'(1);
        end
      end
      lru_pkg::CMD_REMOVE: begin
        if (present) begin
          do_shift  = 1'b1;
          held_next = held - CW'(1);
        end
      end
      lru_pkg::CMD_CLEAR: begin
        held_next = '0;
      end
      default: begin
      end
    endcase
  end

  // close the gap and place the key at the most-recent end
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_shift && at_or_after[i] && (i < ENTRIES - 1)) begin
        keys_next[i] = keys[(i < ENTRIES - 1) ? i + 1 : i];
      end else begin
        keys_next[i] = keys[i];
      end
      if (do_write && (wpos == CW'(i))) begin
        keys_next[i] = key_m;
      end
    end
  end

  // describe the list after this item
  always_comb begin
    result.oldest_valid = (held_next != '0);
    result.oldest_key   = result.oldest_valid ? lru_pkg::KEY_W'(keys_next[0]) : '0;
    result.was_present  = present && ((item.cmd == lru_pkg::CMD_USE) ||
                                      (item.cmd == lru_pkg::CMD_REMOVE));
    result.fill_count   = lru_pkg::COUNT_W'(held_next);
    result.overflow     = refused;
  end

  // hold the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (step) begin
      held <= held_next;
    end
  end

  // hold the key row
  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < ENTRIES; i++) begin
        keys[i] <= keys_next[i];
      end
    end
  end

endmodule
`default_nettype wire

[src/lru_recency_tracker_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_recency_tracker_unit: true-LRU recency list of key identifiers
// Use, remove and clear commands on a list kept in order of last use.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while the skid register is empty. A result
// is registered in the output register, or in the skid register while the
// output stalls. The rate rests on the parallel compare and shift over the
// row of ENTRIES key registers; with the skid register a new item is taken
// while one result waits. After reset the list is empty at once: no clearing
// pass. Keys are held at the narrower of KEY_BITS and the 16-bit key field.
module lru_recency_tracker_unit #(
  parameter int unsigned ENTRIES  = lru_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS = lru_pkg::KEY_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire lru_pkg::item_t   item,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output lru_pkg::result_t      res
);

  lru_pkg::result_t result_new;
  lru_pkg::result_t skid;
  logic             skid_valid;
  logic             accept;

  assign item_ready = !skid_valid;
  assign accept     = item_valid && item_ready;

  lru_core #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (accept),
    .item   (item),
    .result (result_new)
  );

  // advance results through the output and skid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || res_ready) begin
      if (skid_valid) begin
        res        <= skid;
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res       <= result_new;
        res_valid <= accept;
      end
    end else if (accept) begin
      skid       <= result_new;
      skid_valid <= 1'b1;
    end
  end

endmodule
`default_nettype wire

[src/lru_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_checker: port-level checks of the LRU recency tracker
// Watches the top-level ports and reports broken rules by $error.
// ----------------------------------------------------------------------------
module lru_checker #(
  parameter int unsigned ENTRIES = lru_pkg::ENTRIES_DEF
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_ready,
  input wire logic             res_valid,
  input wire logic             res_ready,
  input wire lru_pkg::result_t res
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result changed");

  // a refused key leaves a full list and was not found
  a_overflow: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.overflow |->
      !res.was_present && (res.fill_count == lru_pkg::COUNT_W'(ENTRIES)))
    else $error("overflow without a full list");

  // an empty list shows no oldest key
  a_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.oldest_valid |-> (res.oldest_key == '0) && (res.fill_count == '0))
    else $error("empty list shows a key");

  // items are refused only while a result waits
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> res_valid)
    else $error("input stalled with no result waiting");

  // nothing is shown straight after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid && item_ready)
    else $error("result shown after reset");

endmodule

bind lru_recency_tracker_unit lru_checker #(
  .ENTRIES (ENTRIES)
) u_lru_checker (
  .clk        (clk),
  .rst        (rst),
  .item_ready (item_ready),
  .res_valid  (res_valid),
  .res_ready  (res_ready),
  .res        (res)
);
`default_nettype wire
